[hdl/lpsh_pkg.sv]
// Shared types, constants and helpers for the linear probe string hash table.
// Used by lpsh_hash, the top level and the checker; depends on nothing.
`default_nettype none
package lpsh_pkg;

	// Default sizing, handed to the top level parameters
	localparam int MAX_CAPACITY_D = 1024;
	localparam int KEY_BYTES_D    = 32;
	localparam int VALUE_BITS_D   = 32;

	// Fixed port field widths
	localparam int CFG_W     = 4;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 88;
	localparam int OUT_VAL_W = 32;
	localparam int OUT_CNT_W = 11;
	localparam int OUT_LG_W  = 4;

	localparam logic [CFG_W-1:0] INIT_LOG2_RST = 4'd3;

	// FNV-1a 64: prime is 2^40 + 2^8 + 0xB3
	localparam logic [63:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam logic [7:0]  PRIME_LO   = 8'hB3;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISSING  = 2'd1,
		ST_FULL     = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef struct packed {
		logic [63:0] hash;
		logic        ovf;
		logic        busy;
	} hash_stat_t;

	function automatic logic [63:0] fnv_mul(input logic [63:0] x);
		return (x << 40) + (x << 8) + (x * 64'(PRIME_LO));
	endfunction

endpackage
`default_nettype wire

[hdl/lpsh_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none
module lpsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hdl/lpsh_hash.sv]
// Key byte front end: running FNV-1a 64 hash, key length and overflow flag.
// Depends on lpsh_pkg.
`default_nettype none
module lpsh_hash #(
	parameter int KEY_BYTES = lpsh_pkg::KEY_BYTES_D,
	localparam int LEN_W = $clog2(KEY_BYTES + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [7:0]        key_byte,
	input  wire logic              clear,
	output lpsh_pkg::hash_stat_t   stat,
	output logic      [LEN_W-1:0]  len
);

	logic [63:0]      h_q;
	logic [63:0]      hx_s1;
	logic             pend_q;
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= lpsh_pkg::HASH_BASIS;
			pend_q <= 1'b0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (clear) begin
			h_q    <= lpsh_pkg::HASH_BASIS;
			pend_q <= 1'b0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (take) begin
			pend_q <= 1'b1;
			if (len_q < LEN_W'(KEY_BYTES)) begin
				len_q <= len_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end else if (pend_q) begin
			h_q    <= lpsh_pkg::fnv_mul(hx_s1);
			pend_q <= 1'b0;
		end
	end

	// xor stage; multiply by the prime in the following cycle
	always_ff @(posedge clk) begin
		if (take) begin
			hx_s1 <= h_q ^ {56'd0, key_byte};
		end
	end

	assign stat.hash = h_q;
	assign stat.ovf  = ovf_q;
	assign stat.busy = pend_q;
	assign len       = len_q;

endmodule
`default_nettype wire

[hdl/linear_probe_string_hash_table_unit.sv]
// String-keyed map engine, top level: probe sequencer and table memories.
// Depends on lpsh_pkg, lpsh_ram and lpsh_hash.
//
// Use: key bytes arrive on the s_ channel, one per beat, tlast on the final
// byte, tuser the opcode (0 get, 1 set); new_value rides with the last beat.
// Each byte passes through the FNV unit as a xor step, then a multiply. After
// the last byte one shared probe sequencer runs: each probed slot takes a
// meta RAM read, plus a byte-by-byte key compare on a hash and length
// match; an insert copies the key byte by byte. A set that finds the table
// at least half full first doubles it, unless it is at the largest size:
// clear of the new bank, then a read of each old slot plus the probe for
// each entry moved. s_tready is low for all of that time.
// One result beat per last byte leaves on m_ through an output register;
// the next key may stream in while it waits. If the receiver stalls, the
// next operation holds in its final step until the register frees.
// Reset and every cfg write empty the map and start a clearing pass over
// bank 0 of the slot memory, 2^floor(log2(MAX_CAPACITY)) slots (1024 by
// default); s_tready stays low meanwhile. cfg is always ready.
`default_nettype none
module linear_probe_string_hash_table_unit #(
	parameter int MAX_CAPACITY = lpsh_pkg::MAX_CAPACITY_D,
	parameter int KEY_BYTES    = lpsh_pkg::KEY_BYTES_D,
	parameter int VALUE_BITS   = lpsh_pkg::VALUE_BITS_D
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [lpsh_pkg::S_TDATA_W-1:0] s_tdata,  // key_byte, new_value
	input  wire logic                           s_tlast,
	input  wire logic                           s_tuser,  // opcode
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// status, read_value, released, released_value, entry_count, capacity_log2_now
	output logic      [lpsh_pkg::M_TDATA_W-1:0] m_tdata,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [lpsh_pkg::CFG_W-1:0]     cfg_data
);

	localparam int SLOT_W = $clog2(MAX_CAPACITY + 1) - 1;
	localparam int CNT_W  = SLOT_W + 1;
	localparam int LG_W   = $clog2(SLOT_W + 1);
	localparam int KB_W   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int LEN_W  = $clog2(KEY_BYTES + 1);
	localparam int M_V    = 0;
	localparam int M_LEN  = 1;
	localparam int M_HASH = M_LEN + LEN_W;
	localparam int M_VAL  = M_HASH + 64;
	localparam int M_PTR  = M_VAL + VALUE_BITS;
	localparam int MW     = M_PTR + SLOT_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH, S_OP, S_GCLR, S_GRD, S_GCHK, S_PSTART,
		S_PRD, S_PCHK, S_KRD, S_KCHK, S_ACT, S_CRD, S_CWR, S_DONE
	} state_t;

	typedef enum logic [1:0] {RES_FOUND, RES_EMPTY, RES_NONE} res_t;

	function automatic logic [LG_W-1:0] sat_log2(input logic [lpsh_pkg::CFG_W-1:0] v);
		if (32'(v) > SLOT_W) begin
			return LG_W'(SLOT_W);
		end
		return LG_W'(v);
	endfunction

	state_t                 state_q;
	res_t                   res_q;
	logic [SLOT_W-1:0]      clr_q;
	logic                   bank_q;
	logic [LG_W-1:0]        log2_q;
	logic [CNT_W-1:0]       held_q;
	logic                   grow_q;
	logic [SLOT_W-1:0]      gi_q;
	logic [SLOT_W-1:0]      idx_q;
	logic [SLOT_W-1:0]      n_q;
	logic [LEN_W-1:0]       kc_q;
	logic                   op_q;
	logic [VALUE_BITS-1:0]  nv_q;
	logic [MW-1:0]          ent_q;
	logic [MW-1:0]          hit_q;
	logic [SLOT_W-1:0]      ins_ptr_q;
	lpsh_pkg::status_t      st_q;
	logic [VALUE_BITS-1:0]  rv_q;
	logic                   rel_q;
	logic [VALUE_BITS-1:0]  relv_q;
	logic                   out_valid_q;
	lpsh_pkg::status_t      o_st_q;
	logic [VALUE_BITS-1:0]  o_rv_q;
	logic                   o_rel_q;
	logic [VALUE_BITS-1:0]  o_relv_q;
	logic [CNT_W-1:0]       o_cnt_q;
	logic [LG_W-1:0]        o_lg_q;

	lpsh_pkg::hash_stat_t   hst;
	logic [LEN_W-1:0]       hlen;
	logic                   accept;
	logic                   cfg_we;
	logic                   can_load;
	logic                   hclr;

	logic [SLOT_W-1:0]      cur_mask;
	logic [SLOT_W-1:0]      nxt_mask;
	logic [SLOT_W-1:0]      pmask;
	logic                   pbank;
	logic [CNT_W-1:0]       half;
	logic [63:0]            phash;

	logic                   m_we;
	logic [SLOT_W:0]        m_waddr;
	logic [MW-1:0]          m_wdata;
	logic [SLOT_W:0]        m_raddr;
	logic [MW-1:0]          m_rdata;
	logic                   i_we;
	logic [7:0]             i_rdata;
	logic                   k_we;
	logic [SLOT_W+KB_W-1:0] k_waddr;
	logic [SLOT_W+KB_W-1:0] k_raddr;
	logic [7:0]             k_rdata;
	logic [MW-1:0]          upd_word;
	logic [MW-1:0]          new_word;
	logic                   k_last;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;
	assign s_tready  = (state_q == S_IDLE) && !hst.busy;
	assign accept    = s_tvalid && s_tready;
	assign can_load  = !out_valid_q || m_tready;
	assign hclr      = cfg_we || ((state_q == S_DONE) && can_load);

	assign cur_mask = SLOT_W'((CNT_W'(1) << log2_q) - CNT_W'(1));
	assign nxt_mask = SLOT_W'((CNT_W'(1) << LG_W'(log2_q + 1'b1)) - CNT_W'(1));
	assign pmask    = grow_q ? nxt_mask : cur_mask;
	assign pbank    = grow_q ? ~bank_q : bank_q;
	assign half     = (CNT_W'(1) << log2_q) >> 1;
	assign phash    = grow_q ? ent_q[M_HASH +: 64] : hst.hash;
	assign k_last   = (kc_q == LEN_W'(hlen - 1'b1));

	lpsh_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (accept),
		.key_byte (s_tdata[7:0]),
		.clear    (hclr),
		.stat     (hst),
		.len      (hlen)
	);

	// key bytes of the item in flight
	assign i_we = accept && (hlen < LEN_W'(KEY_BYTES));

	lpsh_ram #(.WIDTH(8), .DEPTH(2 ** KB_W)) u_in_key (
		.clk   (clk),
		.we    (i_we),
		.waddr (hlen[KB_W-1:0]),
		.wdata (s_tdata[7:0]),
		.raddr (kc_q[KB_W-1:0]),
		.rdata (i_rdata)
	);

	// stored keys, one row per entry in insertion order
	assign k_we    = (state_q == S_CWR);
	assign k_waddr = {ins_ptr_q, kc_q[KB_W-1:0]};
	assign k_raddr = {hit_q[M_PTR +: SLOT_W], kc_q[KB_W-1:0]};

	lpsh_ram #(.WIDTH(8), .DEPTH(2 ** (SLOT_W + KB_W))) u_key_store (
		.clk   (clk),
		.we    (k_we),
		.waddr (k_waddr),
		.wdata (i_rdata),
		.raddr (k_raddr),
		.rdata (k_rdata)
	);

	always_comb begin
		upd_word = hit_q;
		upd_word[M_VAL +: VALUE_BITS] = nv_q;
	end

	assign new_word = {held_q[SLOT_W-1:0], nv_q, hst.hash, hlen, 1'b1};

	// slot meta: two banks, current table and grow target
	always_comb begin
		m_we    = 1'b0;
		m_waddr = {pbank, idx_q};
		m_wdata = '0;
		m_raddr = {pbank, idx_q};
		case (state_q)
			S_CLEAR: begin
				m_we    = 1'b1;
				m_waddr = {1'b0, clr_q};
			end
			S_GCLR: begin
				m_we    = 1'b1;
				m_waddr = {~bank_q, gi_q};
			end
			S_GRD: begin
				m_raddr = {bank_q, gi_q};
			end
			S_ACT: begin
				if (grow_q) begin
					m_we    = 1'b1;
					m_wdata = ent_q;
				end else if (op_q && (res_q == RES_FOUND)) begin
					m_we    = 1'b1;
					m_wdata = upd_word;
				end else if (op_q && (res_q == RES_EMPTY)) begin
					m_we    = 1'b1;
					m_wdata = new_word;
				end
			end
			default: begin
			end
		endcase
	end

	lpsh_ram #(.WIDTH(MW), .DEPTH(2 ** (SLOT_W + 1))) u_meta (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			res_q       <= RES_NONE;
			clr_q       <= '0;
			bank_q      <= 1'b0;
			log2_q      <= sat_log2(lpsh_pkg::INIT_LOG2_RST);
			held_q      <= '0;
			grow_q      <= 1'b0;
			gi_q        <= '0;
			idx_q       <= '0;
			n_q         <= '0;
			kc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				log2_q  <= sat_log2(cfg_data);
				held_q  <= '0;
				bank_q  <= 1'b0;
				grow_q  <= 1'b0;
				clr_q   <= '0;
				state_q <= S_CLEAR;
			end else begin
				case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == {SLOT_W{1'b1}}) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (accept && s_tlast) begin
							op_q    <= s_tuser;
							nv_q    <= VALUE_BITS'(s_tdata[39:8]);
							state_q <= S_HASH;
						end
					end
					S_HASH: begin
						state_q <= S_OP;
					end
					S_OP: begin
						rv_q   <= '0;
						rel_q  <= 1'b0;
						relv_q <= '0;
						st_q   <= lpsh_pkg::ST_OK;
						grow_q <= 1'b0;
						if (hst.ovf) begin
							st_q    <= lpsh_pkg::ST_TOO_LONG;
							state_q <= S_DONE;
						end else if (op_q && (held_q >= half) &&
						             (log2_q < LG_W'(SLOT_W))) begin
							grow_q  <= 1'b1;
							gi_q    <= '0;
							state_q <= S_GCLR;
						end else begin
							state_q <= S_PSTART;
						end
					end
					S_GCLR: begin
						gi_q <= gi_q + 1'b1;
						if (gi_q == nxt_mask) begin
							gi_q    <= '0;
							state_q <= S_GRD;
						end
					end
					S_GRD: begin
						state_q <= S_GCHK;
					end
					S_GCHK: begin
						ent_q <= m_rdata;
						if (m_rdata[M_V]) begin
							state_q <= S_PSTART;
						end else if (gi_q == cur_mask) begin
							bank_q  <= ~bank_q;
							log2_q  <= log2_q + 1'b1;
							grow_q  <= 1'b0;
							state_q <= S_PSTART;
						end else begin
							gi_q    <= gi_q + 1'b1;
							state_q <= S_GRD;
						end
					end
					S_PSTART: begin
						idx_q   <= phash[SLOT_W-1:0] & pmask;
						n_q     <= '0;
						state_q <= S_PRD;
					end
					S_PRD: begin
						state_q <= S_PCHK;
					end
					S_PCHK: begin
						hit_q <= m_rdata;
						kc_q  <= '0;
						if (!m_rdata[M_V]) begin
							res_q   <= RES_EMPTY;
							state_q <= S_ACT;
						end else if (!grow_q && (m_rdata[M_HASH +: 64] == hst.hash) &&
						             (m_rdata[M_LEN +: LEN_W] == hlen)) begin
							state_q <= S_KRD;
						end else if (n_q == pmask) begin
							res_q   <= RES_NONE;
							state_q <= S_ACT;
						end else begin
							idx_q   <= (idx_q + 1'b1) & pmask;
							n_q     <= n_q + 1'b1;
							state_q <= S_PRD;
						end
					end
					S_KRD: begin
						state_q <= S_KCHK;
					end
					S_KCHK: begin
						if (k_rdata != i_rdata) begin
							// mismatch: move on to the next slot
							if (n_q == pmask) begin
								res_q   <= RES_NONE;
								state_q <= S_ACT;
							end else begin
								idx_q   <= (idx_q + 1'b1) & pmask;
								n_q     <= n_q + 1'b1;
								state_q <= S_PRD;
							end
						end else if (k_last) begin
							res_q   <= RES_FOUND;
							state_q <= S_ACT;
						end else begin
							kc_q    <= kc_q + 1'b1;
							state_q <= S_KRD;
						end
					end
					S_ACT: begin
						state_q <= S_DONE;
						if (grow_q) begin
							if (gi_q == cur_mask) begin
								bank_q  <= ~bank_q;
								log2_q  <= log2_q + 1'b1;
								grow_q  <= 1'b0;
								state_q <= S_PSTART;
							end else begin
								gi_q    <= gi_q + 1'b1;
								state_q <= S_GRD;
							end
						end else if (!op_q) begin
							if (res_q == RES_FOUND) begin
								rv_q <= hit_q[M_VAL +: VALUE_BITS];
							end else begin
								st_q <= lpsh_pkg::ST_MISSING;
							end
						end else begin
							case (res_q)
								RES_FOUND: begin
									rel_q  <= 1'b1;
									relv_q <= hit_q[M_VAL +: VALUE_BITS];
								end
								RES_EMPTY: begin
									ins_ptr_q <= held_q[SLOT_W-1:0];
									held_q    <= held_q + 1'b1;
									kc_q      <= '0;
									state_q   <= S_CRD;
								end
								default: begin
									st_q <= lpsh_pkg::ST_FULL;
								end
							endcase
						end
					end
					S_CRD: begin
						state_q <= S_CWR;
					end
					S_CWR: begin
						if (k_last) begin
							state_q <= S_DONE;
						end else begin
							kc_q    <= kc_q + 1'b1;
							state_q <= S_CRD;
						end
					end
					S_DONE: begin
						// hold until the output register frees
						if (can_load) begin
							out_valid_q <= 1'b1;
							o_st_q      <= st_q;
							o_rv_q      <= rv_q;
							o_rel_q     <= rel_q;
							o_relv_q    <= relv_q;
							o_cnt_q     <= held_q;
							o_lg_q      <= log2_q;
							state_q     <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0,
	                   lpsh_pkg::OUT_LG_W'(o_lg_q),
	                   lpsh_pkg::OUT_CNT_W'(o_cnt_q),
	                   lpsh_pkg::OUT_VAL_W'(o_relv_q),
	                   o_rel_q,
	                   lpsh_pkg::OUT_VAL_W'(o_rv_q),
	                   o_st_q};

endmodule
`default_nettype wire

[hdl/lpsh_checker.sv]
// Port-level checks of the hash table unit over time, bound to the top level.
// Depends on lpsh_pkg and linear_probe_string_hash_table_unit.
`default_nettype none
module lpsh_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           s_tlast,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [lpsh_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic                           cfg_valid,
	input wire logic                           cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !s_tready)
		else $error("input taken during clearing pass");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken while an operation runs");

	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34] |-> m_tdata[1:0] == lpsh_pkg::ST_OK && m_tdata[33:2] == 32'd0)
		else $error("released beat with bad status or read value");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == lpsh_pkg::ST_TOO_LONG || m_tdata[1:0] == lpsh_pkg::ST_FULL)
		|-> !m_tdata[34] && m_tdata[33:2] == 32'd0 && m_tdata[66:35] == 32'd0)
		else $error("failed operation carries data");

endmodule

bind linear_probe_string_hash_table_unit lpsh_checker u_lpsh_checker (.*);
`default_nettype wire
